@@ rtl/source_token_classifier_macros.svh @@
// assertion macros shared by the token classifier modules
`ifndef SOURCE_TOKEN_CLASSIFIER_MACROS_SVH
`define SOURCE_TOKEN_CLASSIFIER_MACROS_SVH

// expression must hold at every clock edge out of reset
`define STC_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define STC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define STC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/stc_pkg.sv @@
// types, keyword table and helpers for the source token classifier
`default_nettype none

package stc_pkg;

  localparam int KwCount    = 49;
  localparam int KwCppCount = 38;
  localparam int KwMaxLen   = 14;
  localparam int KwBits     = 8 * KwMaxLen;

  localparam int CntW        = 8;
  localparam int TokenLenSat = 255;

  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  typedef enum logic [2:0] {
    KindOper    = 3'd0,
    KindCppKw   = 3'd1,
    KindMpiKw   = 3'd2,
    KindInteger = 3'd3,
    KindReal    = 3'd4,
    KindIdent   = 3'd5,
    KindInvalid = 3'd6
  } stc_kind_e;

  typedef struct packed {
    stc_kind_e        kind;
    logic [5:0]       kw_index;
    logic [7:0]       length;
    logic [7:0]       op_char;
    logic             last;
  } stc_result_t;

  // results caused by one item, slot r0 delivered first
  typedef struct packed {
    logic [1:0]  n;
    stc_result_t r0;
    stc_result_t r1;
  } stc_push_t;

  // keyword text, first character in the highest nonzero byte
  localparam logic [KwBits-1:0] KwText [KwCount] = '{
    "if", "else", "while", "do", "break", "continue", "int", "double",
    "float", "return", "char", "case", "sizeof", "long", "short", "typedef",
    "switch", "unsigned", "void", "static", "struct", "goto", "main", "using",
    "namespace", "FILE", "string", "ifstream", "ostream", "const", "#include",
    "iostream", "fstream", "string.h", "stdio.h", "stdlib.h", "math.h",
    "conio.h",
    "mpi.h", "time.h", {"MPI_", "Init"}, {"MPI_Comm", "_size"},
    {"MPI_Comm", "_rank"}, {"MPI_COMM", "_WORLD"}, {"MPI_", "Finalize"},
    {"MPI_", "Send"}, {"MPI_", "Recv"}, {"MPI_", "Scatter"},
    {"MPI_", "Gather"}
  };

  function automatic logic [3:0] kw_len(input int k);
    logic [3:0] n;
    n = 4'd0;
    for (int i = 0; i < KwMaxLen; i++) begin
      if (KwText[k][8*i +: 8] != 8'd0) n = n + 4'd1;
    end
    return n;
  endfunction

  // character of keyword k at position pos, valid for pos below its length
  function automatic logic [7:0] kw_byte(input int k, input logic [3:0] pos);
    logic [3:0]        sh;
    logic [KwBits-1:0] w;
    sh = kw_len(k) - 4'd1 - pos;
    w  = KwText[k] >> {sh, 3'b000};
    return w[7:0];
  endfunction

endpackage

`default_nettype wire

@@ rtl/stc_char_unit.sv @@
// token state, keyword mask narrowing and per-item classification
`default_nettype none
`include "source_token_classifier_macros.svh"

module stc_char_unit
  import stc_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       accept_i,
  input  wire logic [7:0] char_i,
  input  wire logic       end_i,
  output stc_push_t       push_o
);

  logic [KwCount-1:0] mask_q, mask_d, mask_add, mask_eff;
  logic [CntW-1:0]    count_q, count_d, count_add, count_eff;
  logic               digits_q, digits_d, digits_add, digits_eff;
  logic               dd_q, dd_d, dd_add, dd_eff;
  logic               dot_q, dot_d, dot_add, dot_eff;
  logic               first_q, first_d, first_add, first_eff;

  logic        is_delim, is_oper, is_digit, is_dot;
  logic        hit;
  logic [5:0]  hit_idx;
  stc_result_t tok_res, op_res;

  assign is_oper  = (char_i == "+") || (char_i == "-") || (char_i == "*") ||
                    (char_i == "/") || (char_i == "<") || (char_i == ">") ||
                    (char_i == "=");
  assign is_delim = is_oper || (char_i == " ") || (char_i == 8'h0a) ||
                    (char_i == ",") || (char_i == ";") || (char_i == "(") ||
                    (char_i == ")") || (char_i == "[") || (char_i == "]") ||
                    (char_i == "{") || (char_i == "}");
  assign is_digit = (char_i >= "0") && (char_i <= "9");
  assign is_dot   = (char_i == ".");

  // state after adding the character to the pending token
  always_comb begin
    for (int k = 0; k < KwCount; k++) begin
      mask_add[k] = mask_q[k] && (count_q < {4'd0, kw_len(k)}) &&
                    (kw_byte(k, count_q[3:0]) == char_i);
    end
    count_add  = (count_q == CntW'(TokenLenSat)) ? count_q : count_q + 1'b1;
    first_add  = (count_q == '0) ? is_digit : first_q;
    digits_add = digits_q && is_digit;
    dd_add     = dd_q && (is_digit || is_dot);
    dot_add    = dot_q || is_dot;
  end

  // a delimiter flushes the token as it stands, end of text flushes after adding
  assign mask_eff   = is_delim ? mask_q   : mask_add;
  assign count_eff  = is_delim ? count_q  : count_add;
  assign digits_eff = is_delim ? digits_q : digits_add;
  assign dd_eff     = is_delim ? dd_q     : dd_add;
  assign dot_eff    = is_delim ? dot_q    : dot_add;
  assign first_eff  = is_delim ? first_q  : first_add;

  // lowest surviving keyword of exactly the token length
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int m = KwCount - 1; m >= 0; m--) begin
      if (mask_eff[m] && (count_eff == {4'd0, kw_len(m)})) begin
        hit     = 1'b1;
        hit_idx = 6'(m);
      end
    end
  end

  always_comb begin
    tok_res          = '0;
    tok_res.length   = count_eff;
    tok_res.kw_index = '0;
    priority if (hit) begin
      tok_res.kind     = (hit_idx < 6'(KwCppCount)) ? KindCppKw : KindMpiKw;
      tok_res.kw_index = hit_idx;
    end else if (digits_eff) begin
      tok_res.kind = KindInteger;
    end else if (dd_eff && dot_eff) begin
      tok_res.kind = KindReal;
    end else if (!first_eff) begin
      tok_res.kind = KindIdent;
    end else begin
      tok_res.kind = KindInvalid;
    end

    op_res         = '0;
    op_res.kind    = KindOper;
    op_res.length  = 8'd1;
    op_res.op_char = char_i;
  end

  always_comb begin
    push_o = '0;
    if (accept_i) begin
      if (is_delim) begin
        if (count_q != '0) begin
          push_o.r0 = tok_res;
          push_o.r1 = op_res;
          push_o.n  = is_oper ? 2'd2 : 2'd1;
        end else begin
          push_o.r0 = op_res;
          push_o.n  = is_oper ? 2'd1 : 2'd0;
        end
      end else begin
        push_o.r0 = tok_res;
        push_o.n  = end_i ? 2'd1 : 2'd0;
      end
    end
    push_o.r0.last = (push_o.n == 2'd1);
    push_o.r1.last = 1'b1;
  end

  always_comb begin
    mask_d   = mask_q;
    count_d  = count_q;
    digits_d = digits_q;
    dd_d     = dd_q;
    dot_d    = dot_q;
    first_d  = first_q;
    if (accept_i) begin
      if (is_delim || end_i) begin
        mask_d   = '1;
        count_d  = '0;
        digits_d = 1'b1;
        dd_d     = 1'b1;
        dot_d    = 1'b0;
        first_d  = 1'b0;
      end else begin
        mask_d   = mask_add;
        count_d  = count_add;
        digits_d = digits_add;
        dd_d     = dd_add;
        dot_d    = dot_add;
        first_d  = first_add;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q   <= '1;
      count_q  <= '0;
      digits_q <= 1'b1;
      dd_q     <= 1'b1;
      dot_q    <= 1'b0;
      first_q  <= 1'b0;
    end else begin
      mask_q   <= mask_d;
      count_q  <= count_d;
      digits_q <= digits_d;
      dd_q     <= dd_d;
      dot_q    <= dot_d;
      first_q  <= first_d;
    end
  end

  `STC_ASSERT_IMPL(a_pair_order, push_o.n == 2'd2,
    (push_o.r0.kind != KindOper) && (push_o.r1.kind == KindOper),
    "two results must be token then operator")
  `STC_ASSERT_NEXT(a_delim_clears, accept_i && is_delim, count_q == '0,
    "token count not cleared after delimiter")
  `STC_ASSERT_IMPL(a_idle_no_push, !accept_i, push_o.n == 2'd0,
    "results pushed without an accepted item")

endmodule

`default_nettype wire

@@ rtl/stc_out_queue.sv @@
// small result queue taking up to two results per cycle and giving one while ready_i is high
`default_nettype none
`include "source_token_classifier_macros.svh"

module stc_out_queue
  import stc_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire stc_push_t push_i,
  output logic       room_o,
  output logic       valid_o,
  input  wire logic  ready_i,
  output stc_result_t res_o
);

  stc_result_t      mem_q [QDepth];
  logic [QPtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QCntW-1:0] count_q, count_d;
  logic             pop;

  assign pop     = valid_o && ready_i;
  assign valid_o = (count_q != '0);
  assign res_o   = mem_q[rd_q];
  // room for the worst case of two results from the next item
  assign room_o  = (count_q <= QCntW'(QDepth - 2));

  always_comb begin
    wr_d    = wr_q + QPtrW'(push_i.n);
    rd_d    = rd_q + QPtrW'(pop);
    count_d = count_q + QCntW'(push_i.n) - QCntW'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.n != 2'd0) mem_q[wr_q] <= push_i.r0;
    if (push_i.n == 2'd2) mem_q[wr_q + QPtrW'(1)] <= push_i.r1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      count_q <= count_d;
    end
  end

  `STC_ASSERT_ALWAYS(a_count_bound, count_q <= QCntW'(QDepth),
    "result queue count out of range")
  `STC_ASSERT_IMPL(a_push_room, push_i.n != 2'd0, room_o,
    "results pushed without room")
  `STC_ASSERT_NEXT(a_pop_drains, pop && (push_i.n == 2'd0),
    count_q == $past(count_q) - QCntW'(1), "pop did not drain one entry")

endmodule

`default_nettype wire

@@ rtl/source_token_classifier.sv @@
// top level of the source token classifier
`default_nettype none

// Character-serial tokenizer for C++/MPI text. One byte enters per accepted
// item (tlast marks the final byte of the text) and each item yields zero, one
// or two results: a classified token flushed by a delimiter or end of text,
// then an operator result for + - * / < > =. Token state and classification
// sit in combinational logic behind the state registers, so an item is taken
// every cycle while the four-entry result queue has two free slots. Results
// leave at one per cycle from that queue while m_axis_tready is high, so a
// run of items that each give two results is paced by the output port.
// tready drops when the queue holds more than two results.
module source_token_classifier
  import stc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] text_char
  input  wire logic        s_axis_tlast,   // end_of_text
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [2:0] token_kind, [8:3] keyword_index, [16:9] token_length,
  // [24:17] operator_char, [31:25] zero
  output logic [31:0]      m_axis_tdata,
  output logic             m_axis_tlast    // last_of_run
);

  stc_push_t   push;
  stc_result_t res;
  logic        accept;

  assign accept = s_axis_tvalid && s_axis_tready;

  stc_char_unit u_char (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .char_i   (s_axis_tdata),
    .end_i    (s_axis_tlast),
    .push_o   (push)
  );

  stc_out_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .room_o  (s_axis_tready),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .res_o   (res)
  );

  assign m_axis_tdata = {7'd0, res.op_char, res.length, res.kw_index, res.kind};
  assign m_axis_tlast = res.last;

endmodule

`default_nettype wire
